// File: rtl/dlfb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dlfb_pkg
// Shared types and constants of the dense layer forward/backward unit.
// ----------------------------------------------------------------------------
package dlfb_pkg;

    localparam int MAX_INPUTS    = 64;
    localparam int MAX_OUTPUTS   = 64;
    localparam int FRACTION_BITS = 12;

    localparam int IDX_W   = 6;
    localparam int DIM_W   = 7;
    localparam int VAL_W   = 16;
    localparam int PROD_W  = 2 * VAL_W;
    localparam int ACC_W   = 40;
    localparam int GRAD_W  = 48;
    localparam int WADDR_W = 2 * IDX_W;
    localparam int FQ_DEPTH = 4;
    localparam int FQ_PTR_W = 2;
    localparam int OQ_DEPTH = 2;
    localparam int OQ_PTR_W = 1;

    typedef enum logic [2:0] {
        OP_LOAD_W = 3'd0,
        OP_LOAD_B = 3'd1,
        OP_FWD    = 3'd2,
        OP_BWD    = 3'd3,
        OP_RD_WG  = 3'd4,
        OP_RD_BG  = 3'd5,
        OP_CLEAR  = 3'd6,
        OP_NOP    = 3'd7
    } t_op;

    typedef enum logic [1:0] {
        RK_FWD = 2'd0,
        RK_DX  = 2'd1,
        RK_WG  = 2'd2,
        RK_BG  = 2'd3
    } t_rkind;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_FWD,
        MODE_BWD
    } t_mode;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_EMIT_RD,
        ST_EMIT_PUSH,
        ST_READ
    } t_state;

    typedef struct packed {
        t_op                     op;
        logic [IDX_W-1:0]        row;
        logic [IDX_W-1:0]        col;
        logic signed [VAL_W-1:0] value;
    } t_item;

    typedef struct packed {
        t_rkind                   kind;
        logic [IDX_W-1:0]         index;
        logic signed [GRAD_W-1:0] value;
        logic                     last;
    } t_result;

    typedef struct packed {
        logic [DIM_W-1:0] n_in;
        logic [DIM_W-1:0] n_out;
        logic             abort;
    } t_cfg;

endpackage
`default_nettype wire

// File: rtl/dlfb_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dlfb_front
// Input queue: takes items, classifies the kind and holds them for the engine.
// ----------------------------------------------------------------------------
module dlfb_front import dlfb_pkg::*; (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_push,
    input  wire logic [2:0]               i_kind,
    input  wire logic [IDX_W-1:0]         i_row_index,
    input  wire logic [IDX_W-1:0]         i_column_index,
    input  wire logic signed [VAL_W-1:0]  i_value,
    output logic                          o_full,
    output logic                          o_valid,
    output t_item                         o_item,
    input  wire logic                     i_pop
);

    t_item                r_q [FQ_DEPTH];
    logic [FQ_PTR_W-1:0]  r_wr, r_rd;
    logic [FQ_PTR_W:0]    r_cnt;
    t_item                w_item;

    always_comb begin
        w_item.op    = t_op'(i_kind);
        w_item.row   = i_row_index;
        w_item.col   = i_column_index;
        w_item.value = i_value;
    end

    assign o_full  = (r_cnt == (FQ_PTR_W+1)'(FQ_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wr] <= w_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (FQ_PTR_W+1)'(i_push) - (FQ_PTR_W+1)'(i_pop);
        end
    end

endmodule
`default_nettype wire

// File: rtl/dlfb_outq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dlfb_outq
// Result queue between the engine and the result ports.
// ----------------------------------------------------------------------------
module dlfb_outq import dlfb_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  t_result      i_res,
    output logic         o_full,
    output logic         o_empty,
    output t_result      o_res,
    input  wire logic    i_pop
);

    t_result              r_q [OQ_DEPTH];
    logic [OQ_PTR_W-1:0]  r_wr, r_rd;
    logic [OQ_PTR_W:0]    r_cnt;

    assign o_full  = (r_cnt == (OQ_PTR_W+1)'(OQ_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_res   = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wr] <= i_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (OQ_PTR_W+1)'(i_push) - (OQ_PTR_W+1)'(i_pop);
        end
    end

endmodule
`default_nettype wire

// File: rtl/dlfb_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dlfb_engine
// Back end: stores, MAC pipeline, gradient update, emission and clearing.
// ----------------------------------------------------------------------------
module dlfb_engine import dlfb_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  t_cfg         i_cfg,
    input  wire logic    i_valid,
    input  t_item        i_item,
    output logic         o_pop,
    output logic         o_init_busy,
    input  wire logic    i_out_full,
    output logic         o_push,
    output t_result      o_res
);

    logic signed [VAL_W-1:0]  w_mem   [MAX_INPUTS*MAX_OUTPUTS];
    logic signed [GRAD_W-1:0] wg_mem  [MAX_INPUTS*MAX_OUTPUTS];
    logic signed [VAL_W-1:0]  b_mem   [MAX_OUTPUTS];
    logic signed [GRAD_W-1:0] bg_mem  [MAX_OUTPUTS];
    logic signed [VAL_W-1:0]  act_mem [MAX_INPUTS];
    logic signed [ACC_W-1:0]  acc_mem [MAX_INPUTS];

    logic [MAX_OUTPUTS-1:0] r_b_valid, r_bg_valid;
    logic [MAX_INPUTS-1:0]  r_act_valid;

    t_state              r_state, n_state;
    t_mode               r_mode, n_mode;
    logic [DIM_W-1:0]    r_count, n_count;
    logic [DIM_W-1:0]    r_j, n_j;
    logic [WADDR_W-1:0]  r_clr, n_clr;
    logic                r_v1, r_v2;

    logic signed [VAL_W-1:0]  r_x;
    logic [IDX_W-1:0]         r_i;
    logic                     r_first, r_fwd;
    logic [DIM_W-1:0]         r_n, r_len;
    logic                     r_rd_wg;
    logic [IDX_W-1:0]         r_rd_col;
    logic [IDX_W-1:0]         r_tag1, r_tag2;

    logic signed [VAL_W-1:0]  r_w_q, r_b_q, r_act_q;
    logic                     r_b_v, r_act_v, r_bg_v;
    logic signed [ACC_W-1:0]  r_acc_q;
    logic signed [GRAD_W-1:0] r_wg_q, r_bg_q;

    logic signed [PROD_W-1:0] r_pw, r_pg;
    logic signed [ACC_W-1:0]  r_base;
    logic signed [GRAD_W-1:0] r_wgb, r_bgb;

    logic pop, push, issue, wr_w, wr_b, wr_act, start, rd_issue, clr_wr, clr_bg;
    logic [DIM_W-1:0]    elem;
    logic                is_fwd;
    logic [WADDR_W-1:0]  w_raddr, wg_raddr;
    logic [IDX_W-1:0]    bg_raddr;

    logic signed [ACC_W:0]    acc_sum;
    logic signed [ACC_W-1:0]  acc_sat;
    logic signed [GRAD_W:0]   wg_sum, bg_sum;
    logic signed [GRAD_W-1:0] wg_sat, bg_sat;
    logic signed [ACC_W:0]    rnd_sum;
    logic signed [ACC_W-FRACTION_BITS:0] rnd_q;
    logic signed [VAL_W-1:0]  rnd_sat;

    localparam logic signed [ACC_W:0] ACC_MAX = (ACC_W+1)'((65'sd1 <<< (ACC_W-1)) - 1);
    localparam logic signed [ACC_W:0] ACC_MIN = -ACC_MAX - 1;
    localparam logic signed [GRAD_W:0] GRAD_MAX = (GRAD_W+1)'((65'sd1 <<< (GRAD_W-1)) - 1);
    localparam logic signed [GRAD_W:0] GRAD_MIN = -GRAD_MAX - 1;
    localparam logic signed [ACC_W-FRACTION_BITS:0] OUT_MAX =
        (ACC_W-FRACTION_BITS+1)'((1 <<< (VAL_W-1)) - 1);
    localparam logic signed [ACC_W-FRACTION_BITS:0] OUT_MIN = -OUT_MAX - 1;

    assign o_init_busy = (r_state == ST_CLEAR);
    assign o_pop  = pop;
    assign o_push = push;

    // saturating adds of stage C and output rounding
    always_comb begin
        acc_sum = (ACC_W+1)'(r_base) + (ACC_W+1)'(r_pw);
        if (acc_sum > ACC_MAX) begin
            acc_sat = ACC_W'(ACC_MAX);
        end else if (acc_sum < ACC_MIN) begin
            acc_sat = ACC_W'(ACC_MIN);
        end else begin
            acc_sat = ACC_W'(acc_sum);
        end
        wg_sum = (GRAD_W+1)'(r_wgb) + (GRAD_W+1)'(r_pg);
        if (wg_sum > GRAD_MAX) begin
            wg_sat = GRAD_W'(GRAD_MAX);
        end else if (wg_sum < GRAD_MIN) begin
            wg_sat = GRAD_W'(GRAD_MIN);
        end else begin
            wg_sat = GRAD_W'(wg_sum);
        end
        bg_sum = (GRAD_W+1)'(r_bgb) + (GRAD_W+1)'(r_x);
        if (bg_sum > GRAD_MAX) begin
            bg_sat = GRAD_W'(GRAD_MAX);
        end else if (bg_sum < GRAD_MIN) begin
            bg_sat = GRAD_W'(GRAD_MIN);
        end else begin
            bg_sat = GRAD_W'(bg_sum);
        end
        rnd_sum = (ACC_W+1)'(r_acc_q) + (ACC_W+1)'(1 <<< (FRACTION_BITS-1));
        rnd_q   = (ACC_W-FRACTION_BITS+1)'(rnd_sum >>> FRACTION_BITS);
        if (rnd_q > OUT_MAX) begin
            rnd_sat = VAL_W'(OUT_MAX);
        end else if (rnd_q < OUT_MIN) begin
            rnd_sat = VAL_W'(OUT_MIN);
        end else begin
            rnd_sat = VAL_W'(rnd_q);
        end
    end

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_mode   = r_mode;
        n_count  = r_count;
        n_j      = r_j;
        n_clr    = r_clr;
        pop      = 1'b0;
        push     = 1'b0;
        issue    = 1'b0;
        wr_w     = 1'b0;
        wr_b     = 1'b0;
        wr_act   = 1'b0;
        start    = 1'b0;
        rd_issue = 1'b0;
        clr_wr   = 1'b0;
        clr_bg   = 1'b0;
        is_fwd   = (i_item.op == OP_FWD);
        elem     = '0;
        o_res.kind  = r_fwd ? RK_FWD : RK_DX;
        o_res.index = r_j[IDX_W-1:0];
        o_res.value = GRAD_W'(rnd_sat);
        o_res.last  = (r_j + 1'b1 == r_n);
        if (r_state == ST_READ) begin
            o_res.kind  = r_rd_wg ? RK_WG : RK_BG;
            o_res.index = r_rd_col;
            o_res.value = r_rd_wg ? r_wg_q : (r_bg_v ? r_bg_q : '0);
            o_res.last  = 1'b1;
        end
        case (r_state)
            ST_CLEAR: begin
                clr_wr = 1'b1;
                n_clr  = r_clr + 1'b1;
                if (r_clr == '1) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_valid) begin
                    pop = 1'b1;
                    case (i_item.op)
                        OP_LOAD_W: wr_w = 1'b1;
                        OP_LOAD_B: wr_b = 1'b1;
                        OP_FWD, OP_BWD: begin
                            if ((is_fwd && r_mode == MODE_FWD) ||
                                (!is_fwd && r_mode == MODE_BWD)) begin
                                elem = r_count;
                            end
                            start   = 1'b1;
                            wr_act  = is_fwd;
                            n_mode  = is_fwd ? MODE_FWD : MODE_BWD;
                            n_count = elem;
                            n_j     = '0;
                            n_state = ST_MAC;
                        end
                        OP_RD_WG, OP_RD_BG: begin
                            rd_issue = 1'b1;
                            n_state  = ST_READ;
                        end
                        OP_CLEAR: begin
                            clr_bg  = 1'b1;
                            n_clr   = '0;
                            n_state = ST_CLEAR;
                        end
                        default: ;
                    endcase
                end
            end
            ST_MAC: begin
                issue = 1'b1;
                n_j   = r_j + 1'b1;
                if (r_j + 1'b1 == r_n) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!r_v1 && !r_v2) begin
                    if (r_count + 1'b1 == r_len) begin
                        n_mode  = MODE_IDLE;
                        n_count = '0;
                        n_j     = '0;
                        n_state = ST_EMIT_RD;
                    end else begin
                        n_count = r_count + 1'b1;
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_EMIT_RD: n_state = ST_EMIT_PUSH;
            ST_EMIT_PUSH: begin
                if (!i_out_full) begin
                    push = 1'b1;
                    if (r_j + 1'b1 == r_n) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_j     = r_j + 1'b1;
                        n_state = ST_EMIT_RD;
                    end
                end
            end
            ST_READ: begin
                if (!i_out_full) begin
                    push    = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
        if (i_cfg.abort) begin
            n_mode  = MODE_IDLE;
            n_count = '0;
        end
    end

    assign w_raddr  = r_fwd ? {r_i, r_j[IDX_W-1:0]} : {r_j[IDX_W-1:0], r_i};
    assign wg_raddr = rd_issue ? {i_item.row, i_item.col} : {r_j[IDX_W-1:0], r_i};
    assign bg_raddr = rd_issue ? i_item.col : elem[IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_mode      <= MODE_IDLE;
            r_count     <= '0;
            r_j         <= '0;
            r_clr       <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_b_valid   <= '0;
            r_bg_valid  <= '0;
            r_act_valid <= '0;
        end else begin
            r_state <= n_state;
            r_mode  <= n_mode;
            r_count <= n_count;
            r_j     <= n_j;
            r_clr   <= n_clr;
            r_v1    <= issue;
            r_v2    <= r_v1;
            if (wr_b) begin
                r_b_valid[i_item.col] <= 1'b1;
            end
            if (wr_act) begin
                r_act_valid[elem[IDX_W-1:0]] <= 1'b1;
            end
            if (clr_bg) begin
                r_bg_valid <= '0;
            end else if (r_v2 && !r_fwd && r_tag2 == '0) begin
                r_bg_valid[r_i] <= 1'b1;
            end
        end
    end

    // item payload and pipeline registers
    always_ff @(posedge i_clk) begin
        if (start) begin
            r_x     <= i_item.value;
            r_i     <= elem[IDX_W-1:0];
            r_first <= (elem == '0);
            r_fwd   <= is_fwd;
            r_n     <= is_fwd ? i_cfg.n_out : i_cfg.n_in;
            r_len   <= is_fwd ? i_cfg.n_in : i_cfg.n_out;
        end
        if (rd_issue) begin
            r_rd_wg  <= (i_item.op == OP_RD_WG);
            r_rd_col <= i_item.col;
        end
        r_tag1 <= r_j[IDX_W-1:0];
        r_tag2 <= r_tag1;
        r_pw   <= r_x * r_w_q;
        r_pg   <= (r_act_v ? r_act_q : VAL_W'(0)) * r_x;
        if (r_first) begin
            r_base <= r_fwd ? ACC_W'(r_b_v ? r_b_q : VAL_W'(0)) <<< FRACTION_BITS
                            : ACC_W'(0);
        end else begin
            r_base <= r_acc_q;
        end
        r_wgb <= r_wg_q;
        r_bgb <= r_bg_v ? r_bg_q : GRAD_W'(0);
    end

    always_ff @(posedge i_clk) begin
        if (wr_w) begin
            w_mem[{i_item.row, i_item.col}] <= i_item.value;
        end
        r_w_q <= w_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (wr_b) begin
            b_mem[i_item.col] <= i_item.value;
        end
        r_b_q <= b_mem[r_j[IDX_W-1:0]];
        r_b_v <= r_b_valid[r_j[IDX_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (wr_act) begin
            act_mem[elem[IDX_W-1:0]] <= i_item.value;
        end
        r_act_q <= act_mem[r_j[IDX_W-1:0]];
        r_act_v <= r_act_valid[r_j[IDX_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (r_v2) begin
            acc_mem[r_tag2] <= acc_sat;
        end
        r_acc_q <= acc_mem[r_j[IDX_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (clr_wr) begin
            wg_mem[r_clr] <= '0;
        end else if (r_v2 && !r_fwd) begin
            wg_mem[{r_tag2, r_i}] <= wg_sat;
        end
        if (issue || rd_issue) begin
            r_wg_q <= wg_mem[wg_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v2 && !r_fwd && r_tag2 == '0) begin
            bg_mem[r_i] <= bg_sat;
        end
        if (start || rd_issue) begin
            r_bg_q <= bg_mem[bg_raddr];
            r_bg_v <= r_bg_valid[bg_raddr];
        end
    end

endmodule
`default_nettype wire

// File: rtl/dense_layer_forward_backward_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dense_layer_forward_backward_unit
// Fixed-point fully connected layer, forward pass and gradient accumulation.
// ----------------------------------------------------------------------------
// After reset, and after every clear item, the unit sweeps the 4096-entry
// weight gradient store; full stays high during that time. Each streamed
// forward or backward element walks one shared multiply-accumulate pipeline
// over N columns, outputs_in_use (forward) or inputs_in_use (backward), one
// per cycle, and the pipeline drains before the next item is taken. The last
// element of a vector is followed by N results, read one at a time from the
// accumulator memory and pushed when the result queue has room. Configure
// only while idle.
// ----------------------------------------------------------------------------
module dense_layer_forward_backward_unit import dlfb_pkg::*; (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     push,
    output logic                          full,
    input  wire logic [2:0]               i_kind,
    input  wire logic [IDX_W-1:0]         i_row_index,
    input  wire logic [IDX_W-1:0]         i_column_index,
    input  wire logic signed [VAL_W-1:0]  i_value,
    output logic                          empty,
    input  wire logic                     pop,
    output logic [1:0]                    o_result_kind,
    output logic [IDX_W-1:0]              o_index,
    output logic signed [GRAD_W-1:0]      o_result_value,
    output logic                          o_last,
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [2:0]               paddr,
    input  wire logic [31:0]              pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    logic [DIM_W-1:0] r_n_in, r_n_out, cfg_clamped, cfg_max;
    logic             cfg_wr;
    t_cfg             cfg;
    logic             fq_full, fq_valid, eng_pop, init_busy, oq_full, eng_push;
    t_item            item;
    t_result          eng_res, out_res;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = paddr[2] ? 32'(r_n_out) : 32'(r_n_in);

    always_comb begin
        cfg_max     = paddr[2] ? DIM_W'(MAX_OUTPUTS) : DIM_W'(MAX_INPUTS);
        cfg_clamped = pwdata[DIM_W-1:0];
        if (cfg_clamped == '0) begin
            cfg_clamped = DIM_W'(1);
        end else if (cfg_clamped > cfg_max) begin
            cfg_clamped = cfg_max;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n_in  <= DIM_W'(MAX_INPUTS);
            r_n_out <= DIM_W'(MAX_OUTPUTS);
        end else if (cfg_wr) begin
            if (paddr[2]) begin
                r_n_out <= cfg_clamped;
            end else begin
                r_n_in <= cfg_clamped;
            end
        end
    end

    assign cfg.n_in  = r_n_in;
    assign cfg.n_out = r_n_out;
    assign cfg.abort = cfg_wr;

    assign full = fq_full || init_busy;

    dlfb_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push && !full),
        .i_kind         (i_kind),
        .i_row_index    (i_row_index),
        .i_column_index (i_column_index),
        .i_value        (i_value),
        .o_full         (fq_full),
        .o_valid        (fq_valid),
        .o_item         (item),
        .i_pop          (eng_pop)
    );

    dlfb_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_valid     (fq_valid),
        .i_item      (item),
        .o_pop       (eng_pop),
        .o_init_busy (init_busy),
        .i_out_full  (oq_full),
        .o_push      (eng_push),
        .o_res       (eng_res)
    );

    dlfb_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (eng_push),
        .i_res   (eng_res),
        .o_full  (oq_full),
        .o_empty (empty),
        .o_res   (out_res),
        .i_pop   (pop && !empty)
    );

    assign o_result_kind  = out_res.kind;
    assign o_index        = out_res.index;
    assign o_result_value = out_res.value;
    assign o_last         = out_res.last;

endmodule
`default_nettype wire
